@@ rtl/core/i2cmb_pkg.sv @@
`default_nettype none

package i2cmb_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int PHASE_W = 5;
  localparam int DELAY_W = 16;
  localparam int BIT_CNT_W = 4;

  localparam logic [DELAY_W-1:0] HALF_PERIOD_RESET = 16'd100;

  // write: data bits take steps 1 to 16, then ack clock and release
  localparam logic [PHASE_W-1:0] WR_LAST_BIT_STEP = PHASE_W'(2 * BITS_PER_BYTE);
  localparam logic [PHASE_W-1:0] WR_ACK_HIGH_STEP = PHASE_W'(2 * BITS_PER_BYTE + 1);
  localparam logic [PHASE_W-1:0] WR_ACK_LOW_STEP  = PHASE_W'(2 * BITS_PER_BYTE + 2);
  // read: three steps per bit after the release step, but no gap step after the last bit
  localparam logic [PHASE_W-1:0] RD_END_STEP = PHASE_W'(3 * BITS_PER_BYTE);

  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_STOP  = 3'd1,
    OP_WRITE = 3'd2,
    OP_READ  = 3'd3,
    OP_ACK   = 3'd4,
    OP_NACK  = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    RD_SCL_HIGH = 2'd0,
    RD_SAMPLE   = 2'd1,
    RD_GAP      = 2'd2
  } rd_sub_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/i2cmb_seq.sv @@
`default_nettype none

module i2cmb_seq (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          advance,
  input  wire logic                          cmd_valid,
  input  wire logic [2:0]                    opcode,
  input  wire logic [7:0]                    tx_byte,
  input  wire logic                          sda_in,
  input  wire logic [i2cmb_pkg::DELAY_W-1:0] pause_len,
  output i2cmb_pkg::result_t                 result_next
);
  import i2cmb_pkg::*;

  logic [PHASE_W-1:0]   phase, phase_next;
  opcode_t              command, command_next;
  logic [BIT_CNT_W-1:0] bit_count, bit_count_next;
  logic [DELAY_W-1:0]   delay_count, delay_count_next;
  logic [7:0]           shift_reg, shift_reg_next;
  logic [7:0]           tx_hold, tx_hold_next;
  logic                 ack_reg, ack_reg_next;
  logic                 scl_reg, scl_reg_next;
  logic                 sda_reg, sda_reg_next;
  logic                 sda_drive_reg, sda_drive_reg_next;
  rd_sub_t              rd_sub, rd_sub_next;

  logic                 run;
  logic                 last;
  logic                 done;
  logic [PHASE_W-1:0]   step;
  opcode_t              cmd_sel;

  always_comb begin
    phase_next         = phase;
    command_next       = command;
    bit_count_next     = bit_count;
    delay_count_next   = delay_count;
    shift_reg_next     = shift_reg;
    tx_hold_next       = tx_hold;
    ack_reg_next       = ack_reg;
    scl_reg_next       = scl_reg;
    sda_reg_next       = sda_reg;
    sda_drive_reg_next = sda_drive_reg;
    rd_sub_next        = rd_sub;
    run                = 1'b0;
    last               = 1'b0;
    done               = 1'b0;
    step               = phase;
    cmd_sel            = command;

    if (phase == '0) begin
      if (cmd_valid && (opcode <= 3'(OP_NACK))) begin
        cmd_sel        = opcode_t'(opcode);
        command_next   = opcode_t'(opcode);
        bit_count_next = '0;
        rd_sub_next    = RD_SCL_HIGH;
        if (opcode_t'(opcode) == OP_WRITE) begin
          tx_hold_next = tx_byte;
        end
        if (opcode_t'(opcode) == OP_READ) begin
          shift_reg_next = '0;
        end
        run  = 1'b1;
        step = '0;
      end
    end else if (delay_count > DELAY_W'(1)) begin
      delay_count_next = delay_count - DELAY_W'(1);
    end else begin
      run = 1'b1;
    end

    if (run) begin
      case (cmd_sel)
        OP_START: begin
          case (step)
            PHASE_W'(0): sda_reg_next = 1'b1;
            PHASE_W'(1): scl_reg_next = 1'b1;
            PHASE_W'(2): sda_reg_next = 1'b0;
            PHASE_W'(3): scl_reg_next = 1'b0;
            default:     last = 1'b1;
          endcase
        end
        OP_STOP: begin
          case (step)
            PHASE_W'(0): sda_reg_next = 1'b0;
            PHASE_W'(1): scl_reg_next = 1'b1;
            PHASE_W'(2): sda_reg_next = 1'b1;
            default:     last = 1'b1;
          endcase
        end
        OP_ACK: begin
          case (step)
            PHASE_W'(0): sda_reg_next = 1'b0;
            PHASE_W'(1): scl_reg_next = 1'b0;
            PHASE_W'(2): scl_reg_next = 1'b1;
            PHASE_W'(3): scl_reg_next = 1'b0;
            PHASE_W'(4): sda_reg_next = 1'b0;
            default:     last = 1'b1;
          endcase
        end
        OP_NACK: begin
          case (step)
            PHASE_W'(0): sda_reg_next = 1'b1;
            PHASE_W'(1): scl_reg_next = 1'b1;
            PHASE_W'(2): scl_reg_next = 1'b0;
            PHASE_W'(3): sda_reg_next = 1'b0;
            default:     last = 1'b1;
          endcase
        end
        OP_WRITE: begin
          if (step == '0) begin
            sda_reg_next = tx_hold_next[7];
          end else if (step <= WR_LAST_BIT_STEP) begin
            if (step[0]) begin
              scl_reg_next = 1'b1;
            end else begin
              // next bit goes out with the falling clock
              scl_reg_next   = 1'b0;
              bit_count_next = BIT_CNT_W'(step[PHASE_W-1:1]);
              if (!step[PHASE_W-1]) begin
                sda_reg_next = tx_hold_next[3'd7 - step[3:1]];
              end else begin
                sda_drive_reg_next = 1'b0;
              end
            end
          end else if (step == WR_ACK_HIGH_STEP) begin
            scl_reg_next = 1'b1;
          end else if (step == WR_ACK_LOW_STEP) begin
            ack_reg_next = ~sda_in;
            scl_reg_next = 1'b0;
          end else begin
            sda_drive_reg_next = 1'b1;
            last = 1'b1;
          end
        end
        OP_READ: begin
          if (step == '0) begin
            sda_drive_reg_next = 1'b0;
          end else if (step < RD_END_STEP) begin
            case (rd_sub)
              RD_SCL_HIGH: begin
                scl_reg_next = 1'b1;
                rd_sub_next  = RD_SAMPLE;
              end
              RD_SAMPLE: begin
                shift_reg_next = {shift_reg_next[6:0], sda_in};
                bit_count_next = bit_count_next + BIT_CNT_W'(1);
                scl_reg_next   = 1'b0;
                rd_sub_next    = RD_GAP;
              end
              default: rd_sub_next = RD_SCL_HIGH;
            endcase
          end else begin
            sda_drive_reg_next = 1'b1;
            last = 1'b1;
          end
        end
        default: last = 1'b1;
      endcase

      if (last) begin
        phase_next       = '0;
        delay_count_next = '0;
        done             = 1'b1;
      end else begin
        phase_next       = step + PHASE_W'(1);
        delay_count_next = pause_len;
      end
    end
  end

  always_comb begin
    result_next.scl_level = scl_reg_next;
    result_next.sda_level = sda_reg_next;
    result_next.sda_drive = sda_drive_reg_next;
    result_next.busy_res  = (phase_next != '0);
    result_next.done_res  = done;
    result_next.rx_byte   = shift_reg_next;
    result_next.ack_seen  = ack_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= '0;
      command       <= OP_START;
      bit_count     <= '0;
      delay_count   <= '0;
      shift_reg     <= '0;
      tx_hold       <= '0;
      ack_reg       <= 1'b0;
      scl_reg       <= 1'b1;
      sda_reg       <= 1'b1;
      sda_drive_reg <= 1'b1;
      rd_sub        <= RD_SCL_HIGH;
    end else if (advance) begin
      phase         <= phase_next;
      command       <= command_next;
      bit_count     <= bit_count_next;
      delay_count   <= delay_count_next;
      shift_reg     <= shift_reg_next;
      tx_hold       <= tx_hold_next;
      ack_reg       <= ack_reg_next;
      scl_reg       <= scl_reg_next;
      sda_reg       <= sda_reg_next;
      sda_drive_reg <= sda_drive_reg_next;
      rd_sub        <= rd_sub_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/i2c_master_bit_engine.sv @@
// Tick-driven I2C master pin sequencer. Every transfer on the input channel is one tick and
// yields exactly one result transfer with the SCL/SDA pin levels, SDA drive enable, busy,
// done, receive byte and acknowledge flag after that tick. A tick is accepted every clock
// cycle: it passes through an input register, one step of the sequencer, and an output
// register, so stalls on the output side only back up the input when both registers are
// full. Commands start on the accepting tick; each later pin step comes half_period_ticks
// ticks after the previous one (0 acts as 1), and commands seen while busy, or with
// opcodes 6 and 7, are ignored. half_period_ticks resets to 100 and may be written only
// while no ticks are in flight.
`default_nettype none

module i2c_master_bit_engine (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] half_period_ticks,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        cmd_valid,
  input  wire logic [2:0]  opcode,
  input  wire logic [7:0]  tx_byte,
  input  wire logic        sda_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             scl_level,
  output logic             sda_level,
  output logic             sda_drive,
  output logic             busy_res,
  output logic             done_res,
  output logic [7:0]       rx_byte,
  output logic             ack_seen
);
  import i2cmb_pkg::*;

  logic [DELAY_W-1:0] half_period;
  logic [DELAY_W-1:0] pause_len;

  logic               in_full;
  logic               in_cmd_valid;
  logic [2:0]         in_opcode;
  logic [7:0]         in_tx_byte;
  logic               in_sda;
  logic               advance;

  result_t            result_next;
  result_t            result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_PERIOD_RESET;
    end else if (cfg_valid) begin
      half_period <= half_period_ticks;
    end
  end

  assign pause_len = (half_period == '0) ? DELAY_W'(1) : half_period;

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_cmd_valid <= cmd_valid;
      in_opcode    <= opcode;
      in_tx_byte   <= tx_byte;
      in_sda       <= sda_in;
    end
  end

  i2cmb_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .cmd_valid   (in_cmd_valid),
    .opcode      (in_opcode),
    .tx_byte     (in_tx_byte),
    .sda_in      (in_sda),
    .pause_len   (pause_len),
    .result_next (result_next)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign scl_level = result.scl_level;
  assign sda_level = result.sda_level;
  assign sda_drive = result.sda_drive;
  assign busy_res  = result.busy_res;
  assign done_res  = result.done_res;
  assign rx_byte   = result.rx_byte;
  assign ack_seen  = result.ack_seen;

endmodule

`default_nettype wire

@@ verif/tb_i2c_master_bit_engine.sv @@
`timescale 1ns / 100ps

module tb_i2c_master_bit_engine;
  import i2cmb_pkg::*;

  localparam int SETTLE_CYCLES = 8;

  typedef enum int {
    SDA_RANDOM,
    SDA_ZERO,
    SDA_ONE
  } sda_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] half_period_ticks = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        cmd_valid = 1'b0;
  logic [2:0]  opcode = '0;
  logic [7:0]  tx_byte = '0;
  logic        sda_in = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        scl_level;
  logic        sda_level;
  logic        sda_drive;
  logic        busy_res;
  logic        done_res;
  logic [7:0]  rx_byte;
  logic        ack_seen;

  i2c_master_bit_engine dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .half_period_ticks (half_period_ticks),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .cmd_valid         (cmd_valid),
    .opcode            (opcode),
    .tx_byte           (tx_byte),
    .sda_in            (sda_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .scl_level         (scl_level),
    .sda_level         (sda_level),
    .sda_drive         (sda_drive),
    .busy_res          (busy_res),
    .done_res          (done_res),
    .rx_byte           (rx_byte),
    .ack_seen          (ack_seen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // sequencer model state
  logic [15:0] half_period = HALF_PERIOD_RESET;
  logic [4:0]  seq_step = '0;
  opcode_t     seq_op = OP_START;
  logic [15:0] pause_left = '0;
  logic [7:0]  rx_shift = '0;
  logic [7:0]  tx_hold = '0;
  logic        ack_flag = 1'b0;
  logic        scl_q = 1'b1;
  logic        sda_q = 1'b1;
  logic        drive_q = 1'b1;

  result_t pending_pins[$];

  int mismatches = 0;
  int ticks_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;

  function automatic logic [15:0] pause_ticks();
    return (half_period == 16'd0) ? 16'd1 : half_period;
  endfunction

  // one pin-change step of the running command, 1 when it was the last
  function automatic bit apply_pin_step(input logic [4:0] s, input logic sd);
    int i;
    int k;
    i = (int'(s) - 1) / 2;
    k = (int'(s) - 1) % 3;
    case (seq_op)
      OP_START: begin
        case (s)
          5'd0: sda_q = 1'b1;
          5'd1: scl_q = 1'b1;
          5'd2: sda_q = 1'b0;
          5'd3: scl_q = 1'b0;
          default: ;
        endcase
        return s >= 5'd4;
      end
      OP_STOP: begin
        case (s)
          5'd0: sda_q = 1'b0;
          5'd1: scl_q = 1'b1;
          5'd2: sda_q = 1'b1;
          default: ;
        endcase
        return s >= 5'd3;
      end
      OP_ACK: begin
        case (s)
          5'd0: sda_q = 1'b0;
          5'd1: scl_q = 1'b0;
          5'd2: scl_q = 1'b1;
          5'd3: scl_q = 1'b0;
          5'd4: sda_q = 1'b0;
          default: ;
        endcase
        return s >= 5'd5;
      end
      OP_NACK: begin
        case (s)
          5'd0: sda_q = 1'b1;
          5'd1: scl_q = 1'b1;
          5'd2: scl_q = 1'b0;
          5'd3: sda_q = 1'b0;
          default: ;
        endcase
        return s >= 5'd4;
      end
      OP_WRITE: begin
        if (s == 5'd0) begin
          sda_q = tx_hold[7];
        end else if (s <= WR_LAST_BIT_STEP) begin
          if (s[0]) begin
            scl_q = 1'b1;
          end else begin
            scl_q = 1'b0;
            if (i + 1 < BITS_PER_BYTE) sda_q = tx_hold[6 - i];
            else drive_q = 1'b0;
          end
        end else if (s == WR_ACK_HIGH_STEP) begin
          scl_q = 1'b1;
        end else if (s == WR_ACK_LOW_STEP) begin
          ack_flag = ~sd;
          scl_q = 1'b0;
        end else begin
          drive_q = 1'b1;
          return 1'b1;
        end
        return 1'b0;
      end
      OP_READ: begin
        if (s == 5'd0) begin
          drive_q = 1'b0;
        end else if (s < RD_END_STEP) begin
          if (k == int'(RD_SCL_HIGH)) begin
            scl_q = 1'b1;
          end else if (k == int'(RD_SAMPLE)) begin
            rx_shift = {rx_shift[6:0], sd};
            scl_q = 1'b0;
          end
        end else begin
          drive_q = 1'b1;
          return 1'b1;
        end
        return 1'b0;
      end
      default: return 1'b1;
    endcase
  endfunction

  task automatic predict_tick(input logic cv, input logic [2:0] op, input logic [7:0] tb,
                              input logic sd);
    result_t r;
    logic fin;
    fin = 1'b0;
    if (seq_step == 5'd0) begin
      if (cv && op <= OP_NACK) begin
        seq_op = opcode_t'(op);
        if (seq_op == OP_WRITE) tx_hold = tb;
        if (seq_op == OP_READ) rx_shift = '0;
        void'(apply_pin_step(5'd0, sd));
        seq_step = 5'd1;
        pause_left = pause_ticks();
      end
    end else if (pause_left > 16'd1) begin
      pause_left = pause_left - 16'd1;
    end else if (apply_pin_step(seq_step, sd)) begin
      seq_step = 5'd0;
      pause_left = '0;
      fin = 1'b1;
    end else begin
      seq_step = seq_step + 5'd1;
      pause_left = pause_ticks();
    end
    r.scl_level = scl_q;
    r.sda_level = sda_q;
    r.sda_drive = drive_q;
    r.busy_res  = (seq_step != 5'd0);
    r.done_res  = fin;
    r.rx_byte   = rx_shift;
    r.ack_seen  = ack_flag;
    pending_pins.push_back(r);
  endtask

  function automatic logic pick_sda(input sda_mode_t mode);
    case (mode)
      SDA_ZERO: return 1'b0;
      SDA_ONE:  return 1'b1;
      default:  return 1'($urandom);
    endcase
  endfunction

  task automatic send_tick(input logic cv, input logic [2:0] op, input logic [7:0] tb,
                           input logic sd);
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd_valid <= cv;
    opcode    <= op;
    tx_byte   <= tb;
    sda_in    <= sd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_tick(cv, op, tb, sd);
    ticks_sent++;
  endtask

  task automatic noise_tick();
    if ($urandom_range(1, 0))
      send_tick(1'b1, 3'($urandom_range(7, 6)), 8'($urandom), 1'($urandom));
    else
      send_tick(1'b0, 3'($urandom_range(7, 0)), 8'($urandom), 1'($urandom));
  endtask

  // command tick, then ticks carrying random (ignored) commands until it completes
  task automatic run_command(input logic [2:0] op, input logic [7:0] b, input sda_mode_t mode);
    send_tick(1'b1, op, b, pick_sda(mode));
    while (seq_step != 5'd0)
      send_tick(1'($urandom), 3'($urandom_range(7, 0)), 8'($urandom), pick_sda(mode));
  endtask

  task automatic random_frame();
    int n;
    n = $urandom_range(3, 1);
    run_command(OP_START, 8'($urandom), SDA_RANDOM);
    run_command(OP_WRITE, 8'($urandom), SDA_RANDOM);
    repeat (n) begin
      if ($urandom_range(1, 0)) begin
        run_command(OP_WRITE, 8'($urandom), SDA_RANDOM);
      end else begin
        run_command(OP_READ, 8'($urandom), SDA_RANDOM);
        run_command($urandom_range(1, 0) ? OP_ACK : OP_NACK, 8'($urandom), SDA_RANDOM);
      end
      if ($urandom_range(3, 0) == 0) noise_tick();
    end
    run_command(OP_STOP, 8'($urandom), SDA_RANDOM);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_pins.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_half_period(input logic [15:0] v);
    while (seq_step != 5'd0)
      send_tick(1'b0, 3'($urandom_range(7, 0)), 8'($urandom), 1'($urandom));
    wait_drained();
    cfg_valid         <= 1'b1;
    half_period_ticks <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    half_period = v;
  endtask

  // receive side: checks each transfer, then picks next ready
  always @(posedge clk) begin : pin_check
    result_t got;
    result_t want;
    if (!rst && out_valid && out_ready) begin
      got = {scl_level, sda_level, sda_drive, busy_res, done_res, rx_byte, ack_seen};
      if (pending_pins.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: got %b", got);
      end else begin
        want = pending_pins.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"pin mismatch: exp scl %b sda %b drv %b busy %b done %b rx %h ack %b, ",
                      "got scl %b sda %b drv %b busy %b done %b rx %h ack %b"},
                     want.scl_level, want.sda_level, want.sda_drive, want.busy_res,
                     want.done_res, want.rx_byte, want.ack_seen,
                     got.scl_level, got.sda_level, got.sda_drive, got.busy_res,
                     got.done_res, got.rx_byte, got.ack_seen);
        end
      end
    end
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  task automatic test_reset_period();
    run_command(OP_START, 8'($urandom), SDA_RANDOM);
  endtask

  task automatic test_directed_commands();
    write_half_period(16'd1);
    run_command(OP_START, 8'h00, SDA_RANDOM);
    run_command(OP_WRITE, 8'h00, SDA_ZERO);
    run_command(OP_WRITE, 8'hFF, SDA_ONE);
    run_command(OP_WRITE, 8'hA5, SDA_RANDOM);
    run_command(OP_READ, 8'h00, SDA_ONE);
    run_command(OP_READ, 8'hFF, SDA_ZERO);
    run_command(OP_READ, 8'h5A, SDA_RANDOM);
    run_command(OP_ACK, 8'h00, SDA_RANDOM);
    run_command(OP_NACK, 8'h00, SDA_RANDOM);
    run_command(OP_STOP, 8'h00, SDA_RANDOM);
  endtask

  task automatic test_unused_opcodes();
    send_tick(1'b1, 3'd6, 8'hFF, 1'b1);
    send_tick(1'b1, 3'd7, 8'h00, 1'b0);
    send_tick(1'b0, OP_START, 8'h3C, 1'b1);
    run_command(OP_STOP, 8'h00, SDA_RANDOM);
  endtask

  task automatic test_zero_period();
    write_half_period(16'd0);
    run_command(OP_START, 8'($urandom), SDA_RANDOM);
    run_command(OP_WRITE, 8'($urandom), SDA_RANDOM);
    run_command(OP_READ, 8'($urandom), SDA_RANDOM);
    run_command(OP_STOP, 8'($urandom), SDA_RANDOM);
  endtask

  task automatic test_random_traffic();
    int send_pct[4] = '{0, 67, 0, 13};
    int recv_pct[4] = '{0, 0, 67, 13};
    int last;
    for (int p = 0; p < 4; p++) begin
      write_half_period((p == 3) ? 16'($urandom_range(3, 1)) : 16'd1);
      send_idle_pct  = send_pct[p];
      recv_stall_pct = recv_pct[p];
      last = ticks_sent + 40;
      while (ticks_sent < last) begin
        case ($urandom_range(9, 0))
          0: noise_tick();
          1, 2: run_command(3'($urandom_range(5, 0)), 8'($urandom), SDA_RANDOM);
          default: random_frame();
        endcase
      end
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    write_half_period(16'd1);
    hold_left <= 200;
    random_frame();
    wait_drained();
    random_frame();
  endtask

  task automatic test_long_period();
    write_half_period(16'hFFFF);
    send_tick(1'b1, OP_START, 8'($urandom), 1'($urandom));
    repeat (40) send_tick(1'($urandom), 3'($urandom_range(7, 0)), 8'($urandom), 1'($urandom));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_period();
    test_directed_commands();
    test_unused_opcodes();
    test_zero_period();
    test_random_traffic();
    test_backpressure();
    test_long_period();
    wait_drained();
    if (mismatches == 0 && pending_pins.size() == 0) begin
      $display("PASS i2c_master_bit_engine");
    end else begin
      $display("FAIL i2c_master_bit_engine");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAIL i2c_master_bit_engine");
    $finish;
  end

endmodule
